/* src/sat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg
// Shared constants, codes and types of the section address translator.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int MAX_SECTIONS = 16;
	localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);

	localparam int ADDR_W  = 32;
	localparam int FUNC_W  = 2;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;
	localparam int ENTRY_W = 4 * ADDR_W;

	typedef logic [FUNC_W-1:0] func_t;

	localparam func_t FN_LOAD = 2'd0;
	localparam func_t FN_V2F  = 2'd1;
	localparam func_t FN_F2V  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// sequencer -> match unit
	typedef struct packed {
		logic             en;
		logic             clr;
		logic             f2v;
		logic             vld;
		logic [IDX_W-1:0] tag;
	} match_ctrl_t;

	// match unit -> sequencer
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [IDX_W-1:0] tag;
	} match_stat_t;

endpackage

/* src/sat_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_req_if / sat_rsp_if
// Valid/ready channels for translator requests and responses.
// ----------------------------------------------------------------------------
interface sat_req_if;
	import sat_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [SLOT_W-1:0]   entry_index;
	logic [ADDR_W-1:0]   virt_base;
	logic [ADDR_W-1:0]   virt_length;
	logic [ADDR_W-1:0]   raw_base;
	logic [ADDR_W-1:0]   raw_length;
	logic [ADDR_W-1:0]   query_addr;

	modport source (
		output valid, func, entry_index, virt_base, virt_length, raw_base, raw_length,
		       query_addr,
		input  ready
	);
	modport sink (
		input  valid, func, entry_index, virt_base, virt_length, raw_base, raw_length,
		       query_addr,
		output ready
	);
endinterface

interface sat_rsp_if;
	import sat_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   translated_addr;
	logic [SLOT_W-1:0]   hit_section;
	logic                found;

	modport source (
		output valid, translated_addr, hit_section, found,
		input  ready
	);
	modport sink (
		input  valid, translated_addr, hit_section, found,
		output ready
	);
endinterface

/* src/sat_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/sat_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_match
// Shared range compare and offset unit, one table entry per cycle while ctrl.en is high.
// ----------------------------------------------------------------------------
module sat_match (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sat_pkg::match_ctrl_t       ctrl,
	input  logic [sat_pkg::ADDR_W-1:0] query,
	input  logic [sat_pkg::ENTRY_W-1:0] entry,
	output sat_pkg::match_stat_t       stat,
	output logic [sat_pkg::ADDR_W-1:0] off_s2,
	output logic [sat_pkg::ADDR_W-1:0] other_s2
);
	import sat_pkg::*;

	logic [ADDR_W-1:0] vb, vl, rb, rl;
	logic [ADDR_W-1:0] base, len, other;
	logic [ADDR_W:0]   diff;
	logic [ADDR_W:0]   sum;
	logic              hit;
	logic              vld_s2, hit_s2;
	logic [IDX_W-1:0]  tag_s2;

	assign vb = entry[4*ADDR_W-1:3*ADDR_W];
	assign vl = entry[3*ADDR_W-1:2*ADDR_W];
	assign rb = entry[2*ADDR_W-1:ADDR_W];
	assign rl = entry[ADDR_W-1:0];

	always_comb begin
		base  = ctrl.f2v ? rb : vb;
		len   = ctrl.f2v ? rl : vl;
		other = ctrl.f2v ? vb : rb;
		diff  = {1'b0, query} - {1'b0, base};
		sum   = {1'b0, base} + {1'b0, len};
		// no borrow: q >= base; no carry: end does not wrap; offset below length
		hit   = !diff[ADDR_W] && !sum[ADDR_W] && (diff[ADDR_W-1:0] < len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			hit_s2 <= 1'b0;
		end else if (ctrl.clr) begin
			vld_s2 <= 1'b0;
			hit_s2 <= 1'b0;
		end else if (ctrl.en) begin
			vld_s2 <= ctrl.vld;
			hit_s2 <= ctrl.vld && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			tag_s2   <= ctrl.tag;
			off_s2   <= diff[ADDR_W-1:0];
			other_s2 <= other;
		end
	end

	assign stat.vld = vld_s2;
	assign stat.hit = hit_s2;
	assign stat.tag = tag_s2;

endmodule

/* src/section_address_translator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_address_translator_core
// Section table with forward and reverse offset translation.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready request channel. func selects load, virtual-to-file or
//          file-to-virtual. A load writes one table slot and gives no response;
//          an unused func code is dropped.
//   rsp  : valid/ready response channel, one transfer per query.
//   cfg  : cfg_we/cfg_wdata set section_count; write only while idle.
// Timing: a load writes its slot at the request transfer. A query walks the
//   table one slot per cycle through the single read port of the section RAM
//   and one shared compare unit, stopping at the first hit or the last slot;
//   a zero count skips the scan. req.ready is high only while the sequencer
//   is idle, so no new request is taken until the query has finished.
// Reset: section_count clears to zero; table contents stay undefined until
//   loaded. rsp.valid clears.
// Stall: the response sits in an output register; the next request is taken
//   while it waits. A finished query waits in its done state until the output
//   register frees.
// ----------------------------------------------------------------------------
module section_address_translator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	sat_req_if.sink                     req,
	sat_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [sat_pkg::COUNT_W-1:0] cfg_wdata
);
	import sat_pkg::*;

	state_t              state_q, state_d;
	logic [COUNT_W-1:0]  count_q;
	logic [CNT_W-1:0]    lim_q, lim_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [ADDR_W-1:0]   query_q;
	logic                f2v_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    tag_s1;

	logic                req_xfer, is_query, is_load, resolve, issue, rsp_load;
	logic                ram_we;
	logic [IDX_W-1:0]    waddr, raddr;
	logic [ENTRY_W-1:0]  wdata, rdata;

	match_ctrl_t         mctrl;
	match_stat_t         mstat;
	logic [ADDR_W-1:0]   off_s2, other_s2;

	logic                rsp_vld_q, rsp_found_q;
	logic [ADDR_W-1:0]   rsp_addr_q;
	logic [SLOT_W-1:0]   rsp_slot_q;

	assign req_xfer = req.valid && req.ready;
	assign is_query = (req.func == FN_V2F) || (req.func == FN_F2V);
	assign is_load  = (req.func == FN_LOAD) &&
	                  (32'(req.entry_index) < 32'(MAX_SECTIONS));

	always_comb begin
		if (32'(count_q) > 32'(MAX_SECTIONS)) begin
			lim_d = CNT_W'(MAX_SECTIONS);
		end else begin
			lim_d = CNT_W'(count_q);
		end
	end

	assign raddr   = cnt_q[IDX_W-1:0];
	assign issue   = (state_q == ST_SCAN) && (cnt_q < lim_q);
	assign resolve = (state_q == ST_SCAN) && mstat.vld &&
	                 (mstat.hit || ((CNT_W'(mstat.tag) + CNT_W'(1)) == lim_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_xfer && is_query) begin
					state_d = (lim_d == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (resolve) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_vld_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: req.ready = 1'b0;
			ST_DONE: rsp_load  = !rsp_vld_q || rsp.ready;
			default: req.ready = 1'b0;
		endcase
	end

	assign ram_we = req_xfer && is_load;
	assign waddr  = IDX_W'(req.entry_index);
	assign wdata  = {req.virt_base, req.virt_length, req.raw_base, req.raw_length};

	sat_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_SECTIONS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign mctrl.en  = (state_q == ST_SCAN) && !resolve;
	assign mctrl.clr = req_xfer && is_query;
	assign mctrl.f2v = f2v_q;
	assign mctrl.vld = vld_s1;
	assign mctrl.tag = tag_s1;

	sat_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mctrl),
		.query    (query_q),
		.entry    (rdata),
		.stat     (mstat),
		.off_s2   (off_s2),
		.other_s2 (other_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			cnt_q     <= '0;
			lim_q     <= '0;
			vld_s1    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (req_xfer && is_query) begin
				cnt_q <= '0;
				lim_q <= lim_d;
			end else if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			vld_s1 <= issue;
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= raddr;
		if (req_xfer && is_query) begin
			query_q <= req.query_addr;
			f2v_q   <= (req.func == FN_F2V);
		end
		if (rsp_load) begin
			rsp_found_q <= mstat.hit;
			rsp_addr_q  <= mstat.hit ? (other_s2 + off_s2) : '0;
			rsp_slot_q  <= mstat.hit ? SLOT_W'(mstat.tag) : '0;
		end
	end

	assign rsp.valid           = rsp_vld_q;
	assign rsp.translated_addr = rsp_addr_q;
	assign rsp.hit_section     = rsp_slot_q;
	assign rsp.found           = rsp_found_q;

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.translated_addr == '0 && rsp.hit_section == '0)
		else $error("miss response carries nonzero payload");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.func == FN_LOAD && !rsp.valid |=> !rsp.valid)
		else $error("load produced a response");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= lim_q)
		else $error("read counter past section limit");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && mstat.vld && mstat.hit |-> CNT_W'(mstat.tag) < lim_q)
		else $error("hit reported beyond section limit");
`endif

endmodule
